/* sv/bmt_pkg.sv */
package bmt_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    // Rows are grouped in blocks of eight, one row of each block per RAM bank.
    localparam int ROW_BLKS   = MAX_ROWS / 8;
    localparam int COL_BYTES  = MAX_COLS / 8;
    localparam int RBLK_W     = (ROW_BLKS > 1) ? $clog2(ROW_BLKS) : 1;
    localparam int CB_W       = (COL_BYTES > 1) ? $clog2(COL_BYTES) : 1;
    localparam int BANK_AW    = RBLK_W + CB_W;
    localparam int BANK_DEPTH = 2 ** BANK_AW;

    localparam int REG_W = 7;
    localparam int CNT_W = 4;
    localparam int CMP_W = 16;
    localparam int ROW_BLK_CAP = (ROW_BLKS > 15) ? 15 : ROW_BLKS;
    localparam int COL_BYTE_CAP = (COL_BYTES > 15) ? 15 : COL_BYTES;

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD_OK = 2'd0,
        ST_DATA    = 2'd1,
        ST_REJECT  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic reject;
        logic capture;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
    } dp_stat_t;

    // Number of eight-wide groups that a size register selects, from 1 to max_grp.
    function automatic logic [CNT_W-1:0] eff_groups(input logic [REG_W-1:0] size_val,
                                                    input logic [CNT_W-1:0] max_grp);
        logic [CNT_W-1:0] grp;
        grp = size_val[REG_W-1:3];
        if (grp == '0) begin
            grp = CNT_W'(1);
        end
        if (grp > max_grp) begin
            grp = max_grp;
        end
        return grp;
    endfunction

endpackage

/* sv/bmt_ram.sv */
module bmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/bmt_ctrl.sv */
module bmt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    output logic               m_valid,
    input  logic               m_ready,
    input  bmt_pkg::dp_stat_t  stat,
    output bmt_pkg::dp_cmd_t   cmd
);

    bmt_pkg::state_t state_reg;
    bmt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bmt_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (s_command == bmt_pkg::CMD_READ && stat.full) begin
                        state_next = bmt_pkg::S_RD_WAIT;
                    end else begin
                        state_next = bmt_pkg::S_OUT;
                    end
                end
            end
            bmt_pkg::S_RD_WAIT: begin
                state_next = bmt_pkg::S_OUT;
            end
            bmt_pkg::S_OUT: begin
                if (m_ready) begin
                    state_next = bmt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bmt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            bmt_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == bmt_pkg::CMD_LOAD) begin
                        cmd.load   = !stat.full;
                        cmd.reject = stat.full;
                    end else begin
                        cmd.read   = stat.full;
                        cmd.reject = !stat.full;
                    end
                end
            end
            bmt_pkg::S_RD_WAIT: begin
                cmd.capture = 1'b1;
            end
            bmt_pkg::S_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/bmt_datapath.sv */
module bmt_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bmt_pkg::dp_cmd_t              cmd,
    output bmt_pkg::dp_stat_t             stat,
    input  logic [7:0]                    s_data_in,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [bmt_pkg::REG_W-1:0]     cfg_wdata,
    output logic [7:0]                    m_data_out,
    output logic                          m_last,
    output logic [1:0]                    m_status
);

    logic [bmt_pkg::REG_W-1:0] row_count_reg;
    logic [bmt_pkg::REG_W-1:0] col_count_reg;
    logic [bmt_pkg::CNT_W-1:0] row_blks;
    logic [bmt_pkg::CNT_W-1:0] col_bytes;

    // Load position: byte within the row, row within its block, block.
    logic [bmt_pkg::CB_W-1:0]   ld_byte_reg;
    logic [2:0]                 ld_lane_reg;
    logic [bmt_pkg::RBLK_W-1:0] ld_blk_reg;
    // Read position: row block, then column bit, then column byte.
    logic [bmt_pkg::RBLK_W-1:0] rd_blk_reg;
    logic [2:0]                 rd_bit_reg;
    logic [bmt_pkg::CB_W-1:0]   rd_byte_reg;
    logic                       full_reg;

    logic ld_byte_end;
    logic ld_blk_end;
    logic ld_last;
    logic rd_blk_end;
    logic rd_byte_end;
    logic rd_last;

    logic [2:0] sel_reg;
    logic       last_pend_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    bmt_pkg::status_t out_status_reg;

    logic [7:0] bank_rdata [8];
    logic [7:0] gathered;

    assign row_blks  = bmt_pkg::eff_groups(row_count_reg, bmt_pkg::CNT_W'(bmt_pkg::ROW_BLK_CAP));
    assign col_bytes = bmt_pkg::eff_groups(col_count_reg,
                                           bmt_pkg::CNT_W'(bmt_pkg::COL_BYTE_CAP));

    assign ld_byte_end = bmt_pkg::CMP_W'(ld_byte_reg) == bmt_pkg::CMP_W'(col_bytes - 1'b1);
    assign ld_blk_end  = bmt_pkg::CMP_W'(ld_blk_reg) == bmt_pkg::CMP_W'(row_blks - 1'b1);
    assign ld_last     = ld_byte_end && (ld_lane_reg == 3'd7) && ld_blk_end;
    assign rd_blk_end  = bmt_pkg::CMP_W'(rd_blk_reg) == bmt_pkg::CMP_W'(row_blks - 1'b1);
    assign rd_byte_end = bmt_pkg::CMP_W'(rd_byte_reg) == bmt_pkg::CMP_W'(col_bytes - 1'b1);
    assign rd_last     = rd_blk_end && (rd_bit_reg == 3'd7) && rd_byte_end;

    assign stat.full = full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= bmt_pkg::REG_W'(64);
            col_count_reg <= bmt_pkg::REG_W'(64);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bmt_pkg::REG_ROW_COUNT: row_count_reg <= cfg_wdata;
                bmt_pkg::REG_COL_COUNT: col_count_reg <= cfg_wdata;
                default: row_count_reg <= row_count_reg;
            endcase
        end
    end

    // A size write abandons whatever matrix is in progress.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            ld_byte_reg <= '0;
            ld_lane_reg <= '0;
            ld_blk_reg  <= '0;
            rd_blk_reg  <= '0;
            rd_bit_reg  <= '0;
            rd_byte_reg <= '0;
            full_reg    <= 1'b0;
        end else if (cmd.load) begin
            if (ld_last) begin
                ld_byte_reg <= '0;
                ld_lane_reg <= '0;
                ld_blk_reg  <= '0;
                rd_blk_reg  <= '0;
                rd_bit_reg  <= '0;
                rd_byte_reg <= '0;
                full_reg    <= 1'b1;
            end else if (ld_byte_end) begin
                ld_byte_reg <= '0;
                ld_lane_reg <= ld_lane_reg + 3'd1;
                if (ld_lane_reg == 3'd7) begin
                    ld_blk_reg <= ld_blk_reg + 1'b1;
                end
            end else begin
                ld_byte_reg <= ld_byte_reg + 1'b1;
            end
        end else if (cmd.read) begin
            if (rd_last) begin
                rd_blk_reg  <= '0;
                rd_bit_reg  <= '0;
                rd_byte_reg <= '0;
                full_reg    <= 1'b0;
            end else if (rd_blk_end) begin
                rd_blk_reg <= '0;
                rd_bit_reg <= rd_bit_reg + 3'd1;
                if (rd_bit_reg == 3'd7) begin
                    rd_byte_reg <= rd_byte_reg + 1'b1;
                end
            end else begin
                rd_blk_reg <= rd_blk_reg + 1'b1;
            end
        end
    end

    // Eight banks: row lane i of every block lives in bank i, so one read address
    // returns the same column byte of eight consecutive rows.
    for (genvar i = 0; i < 8; i++) begin : g_bank
        bmt_ram #(
            .WIDTH (8),
            .DEPTH (bmt_pkg::BANK_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (cmd.load && (ld_lane_reg == 3'(i))),
            .waddr ({ld_blk_reg, ld_byte_reg}),
            .wdata (s_data_in),
            .re    (cmd.read),
            .raddr ({rd_blk_reg, rd_byte_reg}),
            .rdata (bank_rdata[i])
        );
        assign gathered[i] = bank_rdata[i][sel_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            sel_reg       <= rd_bit_reg;
            last_pend_reg <= rd_last;
        end
        if (cmd.load) begin
            out_data_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= bmt_pkg::ST_LOAD_OK;
        end else if (cmd.reject) begin
            out_data_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= bmt_pkg::ST_REJECT;
        end else if (cmd.capture) begin
            out_data_reg   <= gathered;
            out_last_reg   <= last_pend_reg;
            out_status_reg <= bmt_pkg::ST_DATA;
        end
    end

    assign m_data_out = out_data_reg;
    assign m_last     = out_last_reg;
    assign m_status   = out_status_reg;

endmodule

/* sv/bit_matrix_transpose.sv */
// Bit matrix transpose.
// Input channel (s_valid/s_ready): each beat carries s_command and s_data_in. A load
// command stores s_data_in as the next byte of the matrix, row-major; a read command
// returns the next byte of the transpose, column-major, once the matrix is full.
// Output channel (m_valid/m_ready): exactly one beat per input beat, with m_status
// giving load accepted, data valid or command rejected; m_last marks the final byte.
// Configuration: cfg_wr_en writes cfg_wdata to row_count (index 0) or col_count
// (index 1); any such write restarts loading. Write only while the block is idle.
// A load or rejected command is presented in the cycle after acceptance; a read first
// passes through the registered RAM read across eight banks into the output register.
// One beat is in flight at a time; the input is not ready while a result is pending.
// A stalled receiver holds the result in its output register and blocks new input.
// Reset: synchronous, active low; sizes return to 64x64, the block returns to loading.
// Matrix storage is not cleared; only bytes loaded for the current matrix are read.
module bit_matrix_transpose (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_command,
    input  logic [7:0]                s_data_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_data_out,
    output logic                      m_last,
    output logic [1:0]                m_status,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [bmt_pkg::REG_W-1:0] cfg_wdata
);

    bmt_pkg::dp_cmd_t  cmd;
    bmt_pkg::dp_stat_t stat;

    bmt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bmt_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_data_in  (s_data_in),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .m_data_out (m_data_out),
        .m_last     (m_last),
        .m_status   (m_status)
    );

endmodule

/* sv/bmt_checker.sv */
module bmt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_data_out,
    input logic       m_last,
    input logic [1:0] m_status
);

    // Only one beat is ever in flight.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted a second beat back to back");

    a_no_data_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == bmt_pkg::ST_LOAD_OK || m_status == bmt_pkg::ST_REJECT))
        |-> (m_data_out == 8'd0 && !m_last))
        else $error("load or reject beat carries data or last");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == bmt_pkg::ST_LOAD_OK || m_status == bmt_pkg::ST_DATA
                     || m_status == bmt_pkg::ST_REJECT))
        else $error("undefined status code");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data_out) && $stable(m_last)
                                   && $stable(m_status)))
        else $error("result changed while stalled");

endmodule

bind bit_matrix_transpose bmt_checker u_bmt_checker (.*);
